// ===== rtl/ray_box_slab_intersect_macros.svh =====
// Assertion macros shared by the block's RTL.
`ifndef RAY_BOX_SLAB_INTERSECT_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECT_MACROS_SVH
`ifndef ASSERT_OFF
`define RBS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RBS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/rbs_pkg.sv =====
package rbs_pkg;

  localparam int NUM_AXES  = 3;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5
  } cfg_reg_t;

  // Per-axis status that rides next to the crossing distances.
  typedef struct packed {
    logic zero_dir;
    logic outside;
  } axis_flags_t;

endpackage

// ===== rtl/rbs_if.sv =====
interface ray_in_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] dir_x;
  logic signed [W-1:0] dir_y;
  logic signed [W-1:0] dir_z;
  logic signed [W-1:0] origin_x;
  logic signed [W-1:0] origin_y;
  logic signed [W-1:0] origin_z;
  logic signed [W-1:0] min_dist;
  logic signed [W-1:0] max_dist;

  modport source (output valid, dir_x, dir_y, dir_z, origin_x, origin_y, origin_z,
                  min_dist, max_dist, input ready);
  modport sink (input valid, dir_x, dir_y, dir_z, origin_x, origin_y, origin_z,
                min_dist, max_dist, output ready);
endinterface

interface ray_out_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic                hit;
  logic signed [W-1:0] hit_dist;

  modport source (output valid, hit, hit_dist, input ready);
  modport sink (input valid, hit, hit_dist, output ready);
endinterface

// ===== rtl/rbs_div.sv =====
// Pipelined signed divider: q = sat(num * 2^F / den), truncating toward zero.
// One restoring step per stage, between an input register and a saturating output register.
module rbs_div #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W:0]   num,
  input  logic signed [W-1:0] den,
  output logic signed [W-1:0] q
);
  localparam int NB = W + 1 + F;

  logic [NB-1:0] nq_r  [NB+1];
  logic          neg_r [NB+1];
  logic [W-1:0]  rem_r [NB];
  logic [W-1:0]  d_r   [NB];

  logic [W:0]    num_mag;
  logic [W-1:0]  den_mag;
  logic [NB-1:0] qm;
  logic [W-1:0]  q_r;

  assign num_mag = num[W] ? (~num + 1'b1) : num;
  assign den_mag = den[W-1] ? (~den + 1'b1) : den;

  always_ff @(posedge clk) begin
    if (en) begin
      nq_r[0]  <= {num_mag, {F{1'b0}}};
      neg_r[0] <= num[W] ^ den[W-1];
      rem_r[0] <= '0;
      d_r[0]   <= den_mag;
    end
  end

  for (genvar k = 0; k < NB; k++) begin : g_step
    logic [W:0] r2;
    logic [W:0] sub;
    logic       ge;
    assign r2  = {rem_r[k], nq_r[k][NB-1]};
    assign sub = r2 - {1'b0, d_r[k]};
    assign ge  = (r2 >= {1'b0, d_r[k]});
    always_ff @(posedge clk) begin
      if (en) begin
        nq_r[k+1]  <= {nq_r[k][NB-2:0], ge};
        neg_r[k+1] <= neg_r[k];
      end
    end
    if (k < NB - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1] <= ge ? sub[W-1:0] : r2[W-1:0];
          d_r[k+1]   <= d_r[k];
        end
      end
    end
  end

  assign qm = nq_r[NB];

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_r[NB]) begin
        if (qm > NB'({1'b1, {(W-1){1'b0}}})) begin
          q_r <= {1'b1, {(W-1){1'b0}}};
        end else begin
          q_r <= ~qm[W-1:0] + 1'b1;
        end
      end else begin
        if (qm > NB'({1'b0, {(W-1){1'b1}}})) begin
          q_r <= {1'b0, {(W-1){1'b1}}};
        end else begin
          q_r <= qm[W-1:0];
        end
      end
    end
  end

  assign q = q_r;
endmodule

// ===== rtl/rbs_lane.sv =====
// One axis: picks the far and near planes and divides both in parallel.
module rbs_lane #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [W-1:0]  dir,
  input  logic signed [W-1:0]  pos,
  input  logic signed [W-1:0]  lo,
  input  logic signed [W-1:0]  hi,
  output logic signed [W-1:0]  far_t,
  output logic signed [W-1:0]  near_t,
  output rbs_pkg::axis_flags_t flags
);
  localparam int DIV_LAT = W + F + 3;

  logic signed [W:0]    far_diff_r;
  logic signed [W:0]    near_diff_r;
  logic signed [W-1:0]  dir_r;
  rbs_pkg::axis_flags_t flags_d_r [DIV_LAT+1];
  logic signed [W-1:0]  far_c;
  logic signed [W-1:0]  near_c;

  assign far_c  = dir[W-1] ? lo : hi;
  assign near_c = dir[W-1] ? hi : lo;

  always_ff @(posedge clk) begin
    if (en) begin
      far_diff_r           <= {far_c[W-1], far_c} - {pos[W-1], pos};
      near_diff_r          <= {near_c[W-1], near_c} - {pos[W-1], pos};
      dir_r                <= dir;
      flags_d_r[0].zero_dir <= (dir == '0);
      flags_d_r[0].outside  <= (pos < lo) || (pos > hi);
      for (int i = 1; i <= DIV_LAT; i++) begin
        flags_d_r[i] <= flags_d_r[i-1];
      end
    end
  end

  rbs_div #(.W(W), .F(F)) u_div_far (
    .clk(clk), .en(en), .num(far_diff_r), .den(dir_r), .q(far_t)
  );

  rbs_div #(.W(W), .F(F)) u_div_near (
    .clk(clk), .en(en), .num(near_diff_r), .den(dir_r), .q(near_t)
  );

  assign flags = flags_d_r[DIV_LAT];
endmodule

// ===== rtl/rbs_merge.sv =====
// Narrows [tmin, tmax] one axis per stage, then picks the reported distance.
module rbs_merge #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [W-1:0]  far_t  [rbs_pkg::NUM_AXES],
  input  logic signed [W-1:0]  near_t [rbs_pkg::NUM_AXES],
  input  rbs_pkg::axis_flags_t flags  [rbs_pkg::NUM_AXES],
  input  logic signed [W-1:0]  min_dist,
  input  logic signed [W-1:0]  max_dist,
  output logic                 hit,
  output logic signed [W-1:0]  hit_dist
);
  localparam int NA = rbs_pkg::NUM_AXES;

  logic signed [W-1:0]  far_s  [NA+1][NA];
  logic signed [W-1:0]  near_s [NA+1][NA];
  rbs_pkg::axis_flags_t flg_s  [NA+1][NA];
  logic signed [W-1:0]  tmin_s [NA+1];
  logic signed [W-1:0]  tmax_s [NA+1];
  logic signed [W-1:0]  mind_s [NA+1];
  logic signed [W-1:0]  maxd_s [NA+1];
  logic                 ok_s   [NA+1];
  logic                 hit_r;
  logic signed [W-1:0]  dist_r;
  logic signed [W-1:0]  cand;

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      far_s[0][a]  = far_t[a];
      near_s[0][a] = near_t[a];
      flg_s[0][a]  = flags[a];
    end
    tmin_s[0] = min_dist;
    tmax_s[0] = max_dist;
    mind_s[0] = min_dist;
    maxd_s[0] = max_dist;
    ok_s[0]   = 1'b1;
  end

  for (genvar k = 0; k < NA; k++) begin : g_axis
    logic                ok_n;
    logic signed [W-1:0] tmin_n;
    logic signed [W-1:0] tmax_n;
    always_comb begin
      ok_n   = ok_s[k];
      tmin_n = tmin_s[k];
      tmax_n = tmax_s[k];
      if (ok_s[k]) begin
        if (flg_s[k][k].zero_dir) begin
          ok_n = !flg_s[k][k].outside;
        end else if (far_s[k][k] < tmin_s[k]) begin
          ok_n = 1'b0;
        end else begin
          if (far_s[k][k] <= tmax_s[k]) begin
            tmax_n = far_s[k][k];
          end
          // The near test sees the exit already narrowed by this axis.
          if (near_s[k][k] >= tmin_s[k]) begin
            if (near_s[k][k] > tmax_n) begin
              ok_n = 1'b0;
            end else begin
              tmin_n = near_s[k][k];
            end
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        far_s[k+1]  <= far_s[k];
        near_s[k+1] <= near_s[k];
        flg_s[k+1]  <= flg_s[k];
        tmin_s[k+1] <= tmin_n;
        tmax_s[k+1] <= tmax_n;
        mind_s[k+1] <= mind_s[k];
        maxd_s[k+1] <= maxd_s[k];
        ok_s[k+1]   <= ok_n;
      end
    end
  end

  assign cand = (tmin_s[NA] == mind_s[NA]) ? tmax_s[NA] : tmin_s[NA];

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r  <= ok_s[NA] && (cand < maxd_s[NA]);
      dist_r <= (ok_s[NA] && (cand < maxd_s[NA])) ? cand : maxd_s[NA];
    end
  end

  assign hit      = hit_r;
  assign hit_dist = dist_r;
endmodule

// ===== rtl/ray_box_slab_intersect.sv =====
// Ray versus axis-aligned box test, slab method, signed fixed point with FRAC_BITS
// fraction bits. One ray beat is taken every cycle unless the result side stalls.
// A beat passes through a register that forms the plane offsets, the six pipelined
// restoring dividers (one per plane, three axis lanes side by side), the per-axis
// interval narrowing stages and one output register. A stall on the result
// side holds the whole pipeline. The user must write box corners on the cfg port
// only while no ray is in flight; the block itself does not enforce it.
`include "ray_box_slab_intersect_macros.svh"
module ray_box_slab_intersect #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  ray_in_if.sink                             in_ray,
  ray_out_if.source                          out_res,
  input  logic                               cfg_we,
  input  logic [rbs_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic signed [DATA_WIDTH-1:0]       cfg_wdata
);
  localparam int W        = DATA_WIDTH;
  localparam int NA       = rbs_pkg::NUM_AXES;
  localparam int LANE_LAT = W + FRAC_BITS + 4;
  localparam int TOT      = LANE_LAT + NA + 1;

  logic signed [W-1:0]  box_lo_r [NA];
  logic signed [W-1:0]  box_hi_r [NA];
  logic [TOT-1:0]       vld_r;
  logic signed [W-1:0]  mind_d_r [LANE_LAT];
  logic signed [W-1:0]  maxd_d_r [LANE_LAT];
  logic                 en;
  logic signed [W-1:0]  dir_v  [NA];
  logic signed [W-1:0]  pos_v  [NA];
  logic signed [W-1:0]  far_t  [NA];
  logic signed [W-1:0]  near_t [NA];
  rbs_pkg::axis_flags_t flags  [NA];

  assign en           = !vld_r[TOT-1] || out_res.ready;
  assign in_ray.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NA; a++) begin
        box_lo_r[a] <= '0;
        box_hi_r[a] <= W'(1) << FRAC_BITS;
      end
    end else if (cfg_we) begin
      case (cfg_idx)
        rbs_pkg::REG_BOX_MIN_X: box_lo_r[0] <= cfg_wdata;
        rbs_pkg::REG_BOX_MIN_Y: box_lo_r[1] <= cfg_wdata;
        rbs_pkg::REG_BOX_MIN_Z: box_lo_r[2] <= cfg_wdata;
        rbs_pkg::REG_BOX_MAX_X: box_hi_r[0] <= cfg_wdata;
        rbs_pkg::REG_BOX_MAX_Y: box_hi_r[1] <= cfg_wdata;
        rbs_pkg::REG_BOX_MAX_Z: box_hi_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOT-2:0], in_ray.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mind_d_r[0] <= in_ray.min_dist;
      maxd_d_r[0] <= in_ray.max_dist;
      for (int i = 1; i < LANE_LAT; i++) begin
        mind_d_r[i] <= mind_d_r[i-1];
        maxd_d_r[i] <= maxd_d_r[i-1];
      end
    end
  end

  assign dir_v[0] = in_ray.dir_x;
  assign dir_v[1] = in_ray.dir_y;
  assign dir_v[2] = in_ray.dir_z;
  assign pos_v[0] = in_ray.origin_x;
  assign pos_v[1] = in_ray.origin_y;
  assign pos_v[2] = in_ray.origin_z;

  for (genvar a = 0; a < NA; a++) begin : g_lane
    rbs_lane #(.W(W), .F(FRAC_BITS)) u_lane (
      .clk(clk), .en(en), .dir(dir_v[a]), .pos(pos_v[a]),
      .lo(box_lo_r[a]), .hi(box_hi_r[a]),
      .far_t(far_t[a]), .near_t(near_t[a]), .flags(flags[a])
    );
  end

  rbs_merge #(.W(W)) u_merge (
    .clk(clk), .en(en), .far_t(far_t), .near_t(near_t), .flags(flags),
    .min_dist(mind_d_r[LANE_LAT-1]), .max_dist(maxd_d_r[LANE_LAT-1]),
    .hit(out_res.hit), .hit_dist(out_res.hit_dist)
  );

  assign out_res.valid = vld_r[TOT-1];

  // A held result beat must freeze the intake and every pipeline stage.
  `RBS_ASSERT_IMPL(a_stall_blocks_in, clk, rst_n, out_res.valid && !out_res.ready, !in_ray.ready)
  `RBS_ASSERT_NEXT(a_stall_holds_pipe, clk, rst_n, out_res.valid && !out_res.ready, $stable(vld_r))
endmodule
